FILE: rtl/ordered_list_max_extract_top_assert.svh
// assertion macros shared by the ordered list rtl
// expects clk_i and rst_ni in the scope of the including module
`ifndef ORDERED_LIST_MAX_EXTRACT_TOP_ASSERT_SVH
`define ORDERED_LIST_MAX_EXTRACT_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ole_pkg.sv
// types, codes and helpers for the ordered list with max extraction
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

  localparam int Depth      = 64;
  localparam int ItemWidth  = 32;
  localparam int IdxWidth   = $clog2(Depth);
  localparam int CountWidth = $clog2(Depth + 1);
  localparam int TreeN      = 2 ** IdxWidth;
  localparam int StepWidth  = $clog2(IdxWidth + 1);

  typedef logic signed [ItemWidth-1:0] item_t;
  typedef logic [IdxWidth-1:0]         idx_t;
  typedef logic [CountWidth-1:0]       count_t;

  localparam logic [2:0] OpPush    = 3'd0;
  localparam logic [2:0] OpPop     = 3'd1;
  localparam logic [2:0] OpExists  = 3'd2;
  localparam logic [2:0] OpPeek    = 3'd3;
  localparam logic [2:0] OpExtract = 3'd4;
  localparam logic [2:0] OpReverse = 3'd5;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  // cell actions
  localparam logic [1:0] ActHold      = 2'd0;
  localparam logic [1:0] ActPushFront = 2'd1;
  localparam logic [1:0] ActPushBack  = 2'd2;
  localparam logic [1:0] ActRemove    = 2'd3;

  typedef struct packed {
    logic [2:0]          opcode;
    logic signed [31:0]  item_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0]  result_item;
    logic                found;
    logic [1:0]          status;
    logic [6:0]          item_count;
  } out_t;

  typedef struct packed {
    logic [1:0] action;
    item_t      item;
    count_t     count;
    idx_t       sel;
  } cell_cmd_t;

  typedef struct packed {
    logic  vld;
    item_t val;
    idx_t  idx;
  } node_t;

  // larger value wins; on a tie the node nearer the head wins
  function automatic node_t pick(node_t a, node_t b, logic rev);
    node_t r;
    if (!b.vld) begin
      r = a;
    end else if (!a.vld) begin
      r = b;
    end else if ($signed(a.val) > $signed(b.val)) begin
      r = a;
    end else if ($signed(b.val) > $signed(a.val)) begin
      r = b;
    end else begin
      r = rev ? b : a;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ole_cell.sv
// one storage cell of the list chain, shifts with its neighbors
// depends on ole_pkg
`timescale 1ns / 1ps
`default_nettype none

module ole_cell (
  input  wire                   clk_i,
  input  ole_pkg::idx_t         cell_idx_i,
  input  ole_pkg::cell_cmd_t    cmd_i,
  input  ole_pkg::item_t        left_i,
  input  ole_pkg::item_t        right_i,
  output ole_pkg::item_t        value_o,
  output logic                  valid_o,
  output logic                  match_o
);
  import ole_pkg::*;

  item_t  value_q, value_d;
  count_t my_pos;

  assign my_pos  = CountWidth'(cell_idx_i);
  assign valid_o = my_pos < cmd_i.count;
  assign match_o = valid_o && (value_q == cmd_i.item);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    case (cmd_i.action)
      ActPushFront: value_d = (cell_idx_i == '0) ? cmd_i.item : left_i;
      ActPushBack: begin
        if (my_pos == cmd_i.count) begin
          value_d = cmd_i.item;
        end
      end
      ActRemove: begin
        if (cell_idx_i >= cmd_i.sel) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

FILE: rtl/ole_max_tree.sv
// registered max tree over the cells, one level per cycle while step_i is high
// depends on ole_pkg
`timescale 1ns / 1ps
`default_nettype none

module ole_max_tree (
  input  wire                 clk_i,
  input  wire                 load_i,
  input  wire                 step_i,
  input  wire                 rev_i,
  input  ole_pkg::item_t      cell_val_i [ole_pkg::Depth],
  input  wire [ole_pkg::Depth-1:0] mask_i,
  output ole_pkg::node_t      top_o
);
  import ole_pkg::*;

  node_t node_q [TreeN];
  node_t node_d [TreeN];

  for (genvar g = 0; g < TreeN; g++) begin : g_node
    node_t load_val;
    node_t step_val;

    if (g < Depth) begin : g_leaf
      assign load_val = '{vld: mask_i[g], val: cell_val_i[g], idx: IdxWidth'(g)};
    end else begin : g_pad
      assign load_val = '0;
    end

    // node g collects its two children, leaving the winner in node 0
    if (g < TreeN / 2) begin : g_inner
      assign step_val = pick(node_q[2*g], node_q[2*g+1], rev_i);
    end else begin : g_outer
      assign step_val = node_q[g];
    end

    always_comb begin
      if (load_i) begin
        node_d[g] = load_val;
      end else if (step_i) begin
        node_d[g] = step_val;
      end else begin
        node_d[g] = node_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      node_q[g] <= node_d[g];
    end
  end

  assign top_o = node_q[0];

endmodule

`default_nettype wire

FILE: rtl/ordered_list_max_extract_top.sv
// Ordered list with max extraction. A request enters on in_valid_i/in_ready_o
// carrying an opcode and an item; exactly one result transaction leaves on
// out_valid_o/out_ready_i for each request, in order.
// The list lives in a chain of Depth cells. Pushes and removals shift the
// whole chain at once; reverse only flips which end is the head.
// Push, pop, exists, reverse and requests on an empty list go from accept
// through the execute and done states to the result register; peek and
// extract max also pass through the max tree, which resolves one level per
// cycle, and an apply state. A new request is taken only after the
// previous result is registered, so pushes and extracts do not overlap.
// The output register holds a finished result while the receiver stalls;
// the next request is still accepted and runs up to its result stage,
// where it waits for the register to free up.
// Reset empties the list (count zero, normal orientation) and clears all
// handshake state; stored items are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_max_extract_top_assert.svh"

module ordered_list_max_extract_top (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  ole_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output ole_pkg::out_t   out_data_o
);
  import ole_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SExec  = 3'd1;
  localparam logic [2:0] STree  = 3'd2;
  localparam logic [2:0] SApply = 3'd3;
  localparam logic [2:0] SDone  = 3'd4;

  logic [2:0]           state_q, state_d;
  count_t               count_q, count_d;
  logic                 rev_q, rev_d;
  logic [StepWidth-1:0] step_q, step_d;
  logic [2:0]           op_q, op_d;
  item_t                item_q, item_d;
  out_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_data_q, out_data_d;

  cell_cmd_t            cmd;
  item_t                cell_val [Depth];
  logic [Depth-1:0]     cell_vld;
  logic [Depth-1:0]     cell_match;
  logic [Depth-1:0]     tree_mask;
  count_t               head_pos;
  logic                 tree_load, tree_step;
  node_t                tree_top;

  // cell 0 is the head in normal orientation, cell count-1 when reversed
  assign head_pos = rev_q ? (count_q - CountWidth'(1)) : '0;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    item_t left_val;
    item_t right_val;

    if (g == 0) begin : g_first
      assign left_val = item_q;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign right_val = cell_val[g];
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end

    ole_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IdxWidth'(g)),
      .cmd_i      (cmd),
      .left_i     (left_val),
      .right_i    (right_val),
      .value_o    (cell_val[g]),
      .valid_o    (cell_vld[g]),
      .match_o    (cell_match[g])
    );

    // peek searches for the single head cell, extract over all live cells
    assign tree_mask[g] = (op_q == OpPeek) ? (CountWidth'(g) == head_pos) : cell_vld[g];
  end

  ole_max_tree u_tree (
    .clk_i      (clk_i),
    .load_i     (tree_load),
    .step_i     (tree_step),
    .rev_i      (rev_q),
    .cell_val_i (cell_val),
    .mask_i     (tree_mask),
    .top_o      (tree_top)
  );

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rev_d       = rev_q;
    step_d      = step_q;
    op_d        = op_q;
    item_d      = item_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    tree_load   = 1'b0;
    tree_step   = 1'b0;
    cmd         = '{action: ActHold, item: item_q, count: count_q, sel: '0};

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          op_d    = in_data_i.opcode;
          item_d  = in_data_i.item_value;
          res_d   = '0;
          state_d = SExec;
        end
      end
      SExec: begin
        state_d = SDone;
        if (op_q == OpPush) begin
          if (count_q == CountWidth'(Depth)) begin
            res_d.status = StFull;
          end else begin
            cmd.action = rev_q ? ActPushBack : ActPushFront;
            count_d    = count_q + CountWidth'(1);
          end
        end else if (op_q <= OpReverse && count_q == '0) begin
          res_d.status = StEmpty;
        end else begin
          case (op_q)
            OpPop: begin
              // reversed head sits at the top of the live range, so just shrink
              if (!rev_q) begin
                cmd.action = ActRemove;
              end
              count_d = count_q - CountWidth'(1);
            end
            OpExists: res_d.found = |cell_match;
            OpPeek, OpExtract: begin
              tree_load = 1'b1;
              step_d    = '0;
              state_d   = STree;
            end
            OpReverse: rev_d = !rev_q;
            default: ;
          endcase
        end
      end
      STree: begin
        tree_step = 1'b1;
        step_d    = step_q + StepWidth'(1);
        if (step_q == StepWidth'(IdxWidth - 1)) begin
          state_d = SApply;
        end
      end
      SApply: begin
        res_d.result_item = tree_top.val;
        if (op_q == OpExtract) begin
          cmd.action = ActRemove;
          cmd.sel    = tree_top.idx;
          count_d    = count_q - CountWidth'(1);
        end
        state_d = SDone;
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_data_d            = res_q;
          out_data_d.item_count = 7'(count_q);
          out_valid_d           = 1'b1;
          state_d               = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      rev_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    item_q     <= item_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  `OLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CountWidth'(Depth), "count beyond depth")
  `OLE_ASSERT_NEXT(a_push_grows, (state_q == SExec) && (op_q == OpPush) && (count_q != CountWidth'(Depth)), count_q == $past(count_q) + CountWidth'(1), "push did not grow list")
  `OLE_ASSERT_NEXT(a_extract_shrinks, (state_q == SApply) && (op_q == OpExtract), count_q == $past(count_q) - CountWidth'(1), "extract did not shrink list")
  `OLE_ASSERT_NOW(a_tree_winner, state_q == SApply, tree_top.vld, "max tree has no winner")

endmodule

`default_nettype wire
